// ----- hdl/jsme_pkg.sv -----
// package for the job shop makespan evaluator
// holds item types, status codes and the controller/datapath command and status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package jsme_pkg;

  localparam int NUM_MACH  = 16;
  localparam int JOB_SLOTS = 16;
  localparam int QDEPTH    = 16;
  localparam int DUR_W     = 16;
  localparam int TIME_W    = 24;
  localparam int MIDX_W    = 4;
  localparam int JIDX_W    = 4;
  localparam int STEP_W    = 4;
  localparam int QPTR_W    = 4;
  localparam int QCNT_W    = 5;
  localparam int CFG_W     = 5;
  localparam int ADDR_W    = MIDX_W + QPTR_W;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DEADLOCK = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // configuration register indexes
  localparam logic REG_MACHINES = 1'b0;
  localparam logic REG_JOBS     = 1'b1;

  typedef struct packed {
    logic [MIDX_W-1:0] machine_index;
    logic [JIDX_W-1:0] job_index;
    logic [STEP_W-1:0] job_step;
    logic [DUR_W-1:0]  duration;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] makespan;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [JIDX_W-1:0] job;
    logic [STEP_W-1:0] step;
    logic [DUR_W-1:0]  dur;
  } op_t;

  typedef struct packed {
    logic              clear_sim;
    logic              scan_init;
    logic              eval;
    logic              set_time;
    logic              release_op;
    logic              emit;
    logic [1:0]        code;
    logic [MIDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic             load_error;
    logic             pending;
    logic             any_busy;
    logic [CFG_W-1:0] nm_eff;
    logic             out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/jsme_datapath.sv -----
// datapath: operation store, machine queues, job state, event time and result register
// depends on jsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsme_datapath
  import jsme_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_accept,
  input  wire in_item_t         in_data,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat
);

  logic [CFG_W-1:0]  mach_cfg_r, jobs_cfg_r;
  logic [QCNT_W-1:0] count_r [NUM_MACH];
  logic [QPTR_W-1:0] head_r  [NUM_MACH];
  logic [NUM_MACH-1:0] busy_r;
  logic [JOB_SLOTS-1:0] job_busy_r;
  logic [QCNT_W-1:0] steps_r [JOB_SLOTS];
  logic [TIME_W-1:0] finish_r [NUM_MACH];
  logic [JIDX_W-1:0] run_job_r [NUM_MACH];
  logic [TIME_W-1:0] sim_time_r, next_r, span_r;
  logic              any_r, load_err_r, out_valid_r;
  out_item_t         out_data_r;

  op_t               mem [NUM_MACH*QDEPTH];
  op_t               rd_op_r;

  logic [CFG_W-1:0]  nm_eff;
  logic              in_ok, we, pend, start;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [QPTR_W-1:0] wptr;
  logic [TIME_W-1:0] fin_new, cand_f;
  logic              do_rel;

  // effective machine count, clamped to the hardware size
  assign nm_eff = (mach_cfg_r > CFG_W'(NUM_MACH)) ? CFG_W'(NUM_MACH) : mach_cfg_r;

  // load checks
  assign in_ok = ({1'b0, in_data.machine_index} < mach_cfg_r) &&
                 ({1'b0, in_data.job_index} < jobs_cfg_r) &&
                 (count_r[in_data.machine_index] != QCNT_W'(QDEPTH));
  assign we    = in_accept && in_ok;
  assign wptr  = head_r[in_data.machine_index] +
                 count_r[in_data.machine_index][QPTR_W-1:0];
  assign waddr = {in_data.machine_index, wptr};
  assign raddr = {cmd.idx, head_r[cmd.idx]};

  // operation store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= '{job: in_data.job_index, step: in_data.job_step, dur: in_data.duration};
    end
    rd_op_r <= mem[raddr];
  end

  // any queued work on the machines in use
  always_comb begin
    pend = 1'b0;
    for (int m = 0; m < NUM_MACH; m++) begin
      if ((CFG_W'(m) < nm_eff) && (count_r[m] != '0)) pend = 1'b1;
    end
  end

  // start decision for the machine under evaluation
  assign start   = !busy_r[cmd.idx] && (count_r[cmd.idx] != '0) &&
                   !job_busy_r[rd_op_r.job] &&
                   (steps_r[rd_op_r.job] == {1'b0, rd_op_r.step});
  assign fin_new = sim_time_r + TIME_W'(rd_op_r.dur);
  assign cand_f  = start ? fin_new : finish_r[cmd.idx];
  assign do_rel  = busy_r[cmd.idx] && (finish_r[cmd.idx] <= sim_time_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mach_cfg_r  <= CFG_W'(NUM_MACH);
      jobs_cfg_r  <= CFG_W'(JOB_SLOTS);
      busy_r      <= '0;
      job_busy_r  <= '0;
      any_r       <= 1'b0;
      load_err_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < NUM_MACH; m++) begin
        count_r[m] <= '0;
        head_r[m]  <= '0;
      end
      for (int j = 0; j < JOB_SLOTS; j++) steps_r[j] <= '0;
    end else begin
      // configuration writes
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_MACHINES: mach_cfg_r <= cfg_wdata;
          REG_JOBS:     jobs_cfg_r <= cfg_wdata;
          default:      ;
        endcase
      end
      // loading
      if (we) begin
        count_r[in_data.machine_index] <= count_r[in_data.machine_index] + 1'b1;
      end else if (in_accept) begin
        load_err_r <= 1'b1;
      end
      // new evaluation
      if (cmd.clear_sim) begin
        busy_r     <= '0;
        job_busy_r <= '0;
        for (int j = 0; j < JOB_SLOTS; j++) steps_r[j] <= '0;
      end
      if (cmd.scan_init) any_r <= 1'b0;
      // start a head operation
      if (cmd.eval) begin
        if (start) begin
          busy_r[cmd.idx]          <= 1'b1;
          job_busy_r[rd_op_r.job]  <= 1'b1;
        end
        if (busy_r[cmd.idx] || start) any_r <= 1'b1;
      end
      // release a finished operation
      if (cmd.release_op && do_rel) begin
        busy_r[cmd.idx]                <= 1'b0;
        job_busy_r[run_job_r[cmd.idx]] <= 1'b0;
        steps_r[run_job_r[cmd.idx]]    <= steps_r[run_job_r[cmd.idx]] + 1'b1;
        head_r[cmd.idx]                <= head_r[cmd.idx] + 1'b1;
        count_r[cmd.idx]               <= count_r[cmd.idx] - 1'b1;
      end
      // result and queue clear
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        load_err_r  <= 1'b0;
        for (int m = 0; m < NUM_MACH; m++) begin
          count_r[m] <= '0;
          head_r[m]  <= '0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // timing payload
  always_ff @(posedge clk) begin
    if (cmd.clear_sim) begin
      sim_time_r <= '0;
      span_r     <= '0;
      for (int m = 0; m < NUM_MACH; m++) finish_r[m] <= '0;
    end
    if (cmd.eval) begin
      if (start) begin
        finish_r[cmd.idx]  <= fin_new;
        run_job_r[cmd.idx] <= rd_op_r.job;
        if (fin_new > span_r) span_r <= fin_new;
      end
      if ((busy_r[cmd.idx] || start) && (!any_r || cand_f < next_r)) next_r <= cand_f;
    end
    if (cmd.set_time) sim_time_r <= next_r;
    if (cmd.emit) begin
      out_data_r.makespan <= (cmd.code == STAT_OK) ? span_r : '0;
      out_data_r.status   <= cmd.code;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.load_error = load_err_r;
    stat.pending    = pend;
    stat.any_busy   = any_r;
    stat.nm_eff     = nm_eff;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // each busy machine holds exactly one busy job
  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == $countones(job_busy_r))
    else $error("machine and job busy counts differ");

  // event time never runs backwards
  a_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_time |=> sim_time_r >= $past(sim_time_r))
    else $error("simulation time decreased");

  // a result is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- hdl/jsme_ctrl.sv -----
// controller: sequences loading, sweeps, next-event step, release and result
// depends on jsme_pkg
`timescale 1ns / 1ps
`default_nettype none

module jsme_ctrl
  import jsme_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_accept,
  input  wire logic     in_last,
  input  wire dp_stat_t stat,
  output logic          in_stall,
  output dp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_EV    = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;
  localparam logic [2:0] S_RL    = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] idx_r, idx_nxt;
  logic [1:0]       code_r, code_nxt;
  logic             last_idx;

  assign last_idx = (idx_r + 1'b1) == stat.nm_eff;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    code_nxt       = code_r;
    cmd            = '0;
    cmd.idx        = idx_r[MIDX_W-1:0];
    cmd.code       = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_last) state_nxt = S_START;
      end
      S_START: begin
        cmd.clear_sim = 1'b1;
        if (stat.load_error) begin
          code_nxt  = STAT_OVERFLOW;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!stat.pending) begin
          code_nxt  = STAT_OK;
          state_nxt = S_FIN;
        end else begin
          cmd.scan_init = 1'b1;
          idx_nxt       = '0;
          state_nxt     = S_RD;
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        cmd.eval = 1'b1;
        if (last_idx) begin
          state_nxt = S_NEXT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_NEXT: begin
        if (!stat.any_busy) begin
          code_nxt  = STAT_DEADLOCK;
          state_nxt = S_FIN;
        end else begin
          cmd.set_time = 1'b1;
          idx_nxt      = '0;
          state_nxt    = S_RL;
        end
      end
      S_RL: begin
        cmd.release_op = 1'b1;
        if (last_idx) begin
          state_nxt = S_CHK;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      code_r  <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

`default_nettype wire

// ----- hdl/job_shop_makespan_evaluator.sv -----
// top level of the job shop makespan evaluator
// instantiates jsme_ctrl and jsme_datapath; depends on jsme_pkg
//
// usage:
//   configuration: cfg_wr_en/cfg_index/cfg_wdata set machines in use (index 0)
//   and jobs in use (index 1), only while the block is idle.
//   input channel: in_valid/in_stall/in_data carries one operation per item.
//   operations load one per cycle into their machine queue when idle. an
//   item with last_item set is loaded too and starts the evaluation; in_stall
//   stays high until the result is written to the output register.
//   evaluation runs in sweeps over the M machines in use: a store read and
//   an evaluate step per machine, a next-event step, then a release step per
//   machine. the schedule's event count sets the sweeps; a load error has none.
//   result channel: out_valid/out_stall/out_data carries one item per last
//   item: makespan and status (ok, deadlock or overflow; a bad index gives overflow).
//   a result waiting under out_stall holds; loading of the next schedule
//   goes on meanwhile, and a following last item waits only for the output
//   register to free before it writes its own result.
//   reset (rst_n low, synchronous) empties all queues, clears errors and
//   restores both configuration registers to 16.
`timescale 1ns / 1ps
`default_nettype none

module job_shop_makespan_evaluator
  import jsme_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic     in_accept;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign in_accept = in_valid && !in_stall;

  jsme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_accept(in_accept),
    .in_last  (in_data.last_item),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  jsme_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_accept(in_accept),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

`default_nettype wire
